[design/nicd_pkg.sv]
// Shared types and constants of the NiCd charge controller.
`timescale 1ns / 1ps

package nicd_pkg;

  // Field widths
  localparam int unsigned VOLT_W  = 10;
  localparam int unsigned CUR_W   = 11;
  localparam int unsigned STAGE_W = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CELLS_W = 3;
  localparam int unsigned DUTY_W  = 5;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY_LEVEL = 3'd0,
    CFG_PRE_TARGET  = 3'd1,
    CFG_PRE_WINDOW  = 3'd2,
    CFG_FAST_TARGET = 3'd3,
    CFG_FAST_WINDOW = 3'd4,
    CFG_MAX_DUTY    = 3'd5,
    CFG_TRICKLE_LIM = 3'd6
  } cfg_idx_t;

  // Configuration register file contents
  typedef struct packed {
    logic [VOLT_W-1:0] empty_level_cv;
    logic [CUR_W-1:0]  pre_target_ma;
    logic [9:0]        pre_window_ma;
    logic [CUR_W-1:0]  fast_target_ma;
    logic [9:0]        fast_window_ma;
    logic [DUTY_W-1:0] max_duty;
    logic [CNT_W-1:0]  trickle_limit;
  } cfg_t;

  // Fixed voltage decisions, 10 mV units
  localparam logic [VOLT_W-1:0] SINGLE_MAX_CV = 10'd150;
  localparam logic [VOLT_W-1:0] PACK2_CV      = 10'd200;
  localparam logic [VOLT_W-1:0] PACK4_CV      = 10'd400;
  localparam logic [VOLT_W-1:0] PACK7_CV      = 10'd700;

  // Per-cell thresholds, 10 mV units
  localparam logic [7:0] CELL_LOW_CV  = 8'd130;
  localparam logic [7:0] CELL_MID_CV  = 8'd142;
  localparam logic [7:0] CELL_FULL_CV = 8'd149;
  localparam logic [7:0] CELL_OVER_CV = 8'd150;

  // Seven-cell stack current limits, mA
  localparam logic [CUR_W:0] S7_PRE_LO  = 12'd50;
  localparam logic [CUR_W:0] S7_PRE_HI  = 12'd370;
  localparam logic [CUR_W:0] S7_FAST_LO = 12'd120;
  localparam logic [CUR_W:0] S7_FAST_HI = 12'd400;

  localparam logic [DUTY_W-1:0] PRE_DUTY = 5'd1;

  // Classified tick passed from front to back
  typedef struct packed {
    logic              below_empty;
    logic              lt_single;
    logic              ge_pack2;
    logic              ge_pack4;
    logic              ge_pack7;
    logic              is_zero;
    logic [VOLT_W-1:0] voltage_cv;
    logic [CUR_W-1:0]  current_ma;
  } item_t;

endpackage

[design/nicd_in_if.sv]
// Input channel: one tick of voltage and current samples.
`timescale 1ns / 1ps

interface nicd_in_if;
  import nicd_pkg::*;

  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage_cv;
  logic [CUR_W-1:0]  current_ma;

  modport source (output valid, output voltage_cv, output current_ma, input ready);
  modport sink   (input valid, input voltage_cv, input current_ma, output ready);
endinterface

[design/nicd_out_if.sv]
// Result channel: controller state after each tick.
`timescale 1ns / 1ps

interface nicd_out_if;
  import nicd_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAGE_W-1:0] stage_now;
  logic [KIND_W-1:0]  kind_now;
  logic [CELLS_W-1:0] cells_now;
  logic [DUTY_W-1:0]  duty_out;
  logic               drive_on;

  modport source (output valid, output stage_now, output kind_now, output cells_now,
                  output duty_out, output drive_on, input ready);
  modport sink   (input valid, input stage_now, input kind_now, input cells_now,
                  input duty_out, input drive_on, output ready);
endinterface

[design/nicd_charge_controller.sv]
// Top level of the NiCd charge controller: configuration registers and stage wiring.
`timescale 1ns / 1ps

// NiCd charge controller. Each input beat is one half-second tick with a battery
// voltage sample (10 mV) and a charge current sample (mA); each tick yields exactly
// one result beat with the stage, cell kind, cell count, PWM duty and drive enable
// after that tick. A tick can be taken every cycle while nothing stalls: the front
// registers and classifies the sample, a QUEUE_DEPTH-entry queue decouples it from
// the back, and the back updates the stage machine into the result register, so a
// tick passes the front register, a queue slot and the result register. Configuration
// writes take effect at once and must only be issued while no tick is in flight.
module nicd_charge_controller #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  nicd_in_if.sink                       in_ch,
  nicd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [nicd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [nicd_pkg::CFG_W-1:0]    cfg_data
);
  import nicd_pkg::*;

  cfg_t  cfg_r;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.empty_level_cv <= 10'd50;
      cfg_r.pre_target_ma  <= 11'd350;
      cfg_r.pre_window_ma  <= 10'd100;
      cfg_r.fast_target_ma <= 11'd700;
      cfg_r.fast_window_ma <= 10'd100;
      cfg_r.max_duty       <= 5'd3;
      cfg_r.trickle_limit  <= 10'd186;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_EMPTY_LEVEL: cfg_r.empty_level_cv <= cfg_data[VOLT_W-1:0];
        CFG_PRE_TARGET:  cfg_r.pre_target_ma  <= cfg_data[CUR_W-1:0];
        CFG_PRE_WINDOW:  cfg_r.pre_window_ma  <= cfg_data[9:0];
        CFG_FAST_TARGET: cfg_r.fast_target_ma <= cfg_data[CUR_W-1:0];
        CFG_FAST_WINDOW: cfg_r.fast_window_ma <= cfg_data[9:0];
        CFG_MAX_DUTY:    cfg_r.max_duty       <= cfg_data[DUTY_W-1:0];
        CFG_TRICKLE_LIM: cfg_r.trickle_limit  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  nicd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .empty_level_cv (cfg_r.empty_level_cv),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  nicd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  nicd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg       (cfg_r),
    .out_ch    (out_ch)
  );

endmodule

[design/nicd_front.sv]
// Front stage: accept a tick beat and classify its voltage.
`timescale 1ns / 1ps

module nicd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  nicd_in_if.sink                        in_ch,
  input  logic [nicd_pkg::VOLT_W-1:0]    empty_level_cv,
  output logic                           push_valid,
  input  logic                           push_ready,
  output nicd_pkg::item_t                push_item
);
  import nicd_pkg::*;

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  // Take a new beat when the stage is empty or draining into the queue
  assign in_ch.ready = !valid_r || push_ready;

  // Classify against fixed and configured levels
  always_comb begin
    item_nxt.below_empty = in_ch.voltage_cv < empty_level_cv;
    item_nxt.lt_single   = in_ch.voltage_cv < SINGLE_MAX_CV;
    item_nxt.ge_pack2    = in_ch.voltage_cv >= PACK2_CV;
    item_nxt.ge_pack4    = in_ch.voltage_cv >= PACK4_CV;
    item_nxt.ge_pack7    = in_ch.voltage_cv >= PACK7_CV;
    item_nxt.is_zero     = in_ch.voltage_cv == '0;
    item_nxt.voltage_cv  = in_ch.voltage_cv;
    item_nxt.current_ma  = in_ch.current_ma;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

[design/nicd_queue.sv]
// Short queue of classified ticks between front and back.
`timescale 1ns / 1ps

module nicd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  nicd_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output nicd_pkg::item_t pop_item
);
  import nicd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/nicd_back.sv]
// Back stage: charge stage machine, duty regulation and result register.
`timescale 1ns / 1ps

module nicd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  nicd_pkg::item_t pop_item,
  input  nicd_pkg::cfg_t  cfg,
  nicd_out_if.source      out_ch
);
  import nicd_pkg::*;

  typedef enum logic [STAGE_W-1:0] {
    ST_CELL    = 3'd0,
    ST_TYPE    = 3'd1,
    ST_PACK    = 3'd2,
    ST_PRE     = 3'd3,
    ST_FAST    = 3'd4,
    ST_TRICKLE = 3'd5,
    ST_STOP    = 3'd6,
    ST_ERROR   = 3'd7
  } stage_t;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PACK    = 2'd3;

  stage_t             stage_r, stage_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [CELLS_W-1:0] cells_r, cells_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic               drive_r, drive_nxt;
  logic [CNT_W-1:0]   trick_r, trick_nxt;
  logic               out_valid_r;
  logic               take;

  logic [CUR_W:0]  v_ext;
  logic [CUR_W:0]  cur_ext;
  logic [CUR_W:0]  thr_low, thr_mid, thr_full, thr_over;
  logic [CUR_W:0]  pre_lo, pre_hi, fast_lo, fast_hi;
  logic            seven;

  // Per-cell threshold scaled by the cell count
  function automatic logic [CUR_W:0] scale(input logic [7:0] k, input logic [CELLS_W-1:0] n);
    scale = (CUR_W+1)'(k) * (CUR_W+1)'(n);
  endfunction

  // Step duty up below the floor, then down above the ceiling
  function automatic logic [DUTY_W-1:0] regulate(input logic [DUTY_W-1:0] duty,
                                                input logic [CUR_W:0]    cur,
                                                input logic [CUR_W:0]    lo,
                                                input logic [CUR_W:0]    hi,
                                                input logic [DUTY_W-1:0] max_d);
    logic [DUTY_W:0]   up;
    logic [DUTY_W-1:0] d;
    d  = duty;
    up = {1'b0, duty} + 1'b1;
    if (cur < lo) begin
      if (up > {1'b0, max_d}) up = {1'b0, max_d};
      d = up[DUTY_W-1:0];
    end
    if (cur > hi) begin
      d = (d <= PRE_DUTY) ? PRE_DUTY : d - 1'b1;
    end
    regulate = d;
  endfunction

  assign take      = pop_valid && (!out_valid_r || out_ch.ready);
  assign pop_ready = !out_valid_r || out_ch.ready;

  assign v_ext    = (CUR_W+1)'(pop_item.voltage_cv);
  assign cur_ext  = (CUR_W+1)'(pop_item.current_ma);
  assign thr_low  = scale(CELL_LOW_CV, cells_r);
  assign thr_mid  = scale(CELL_MID_CV, cells_r);
  assign thr_full = scale(CELL_FULL_CV, cells_r);
  assign thr_over = scale(CELL_OVER_CV, cells_r);
  assign seven    = cells_r == CELLS_W'(7);
  assign pre_lo   = seven ? S7_PRE_LO  : (CUR_W+1)'(cfg.pre_target_ma);
  assign pre_hi   = seven ? S7_PRE_HI  :
                    (CUR_W+1)'(cfg.pre_target_ma) + (CUR_W+1)'(cfg.pre_window_ma);
  assign fast_lo  = seven ? S7_FAST_LO : (CUR_W+1)'(cfg.fast_target_ma);
  assign fast_hi  = seven ? S7_FAST_HI :
                    (CUR_W+1)'(cfg.fast_target_ma) + (CUR_W+1)'(cfg.fast_window_ma);

  // Work out the next controller state for one tick
  always_comb begin
    logic mid_hit;
    stage_nxt = stage_r;
    kind_nxt  = kind_r;
    cells_nxt = cells_r;
    duty_nxt  = duty_r;
    drive_nxt = drive_r;
    trick_nxt = trick_r;
    mid_hit   = 1'b0;
    unique case (stage_r)
      ST_CELL: begin
        if (pop_item.below_empty) begin
          duty_nxt  = PRE_DUTY;
          drive_nxt = 1'b1;
        end else begin
          stage_nxt = ST_TYPE;
          drive_nxt = 1'b0;
        end
      end
      ST_TYPE: begin
        duty_nxt  = PRE_DUTY;
        drive_nxt = 1'b1;
        if (pop_item.lt_single) begin
          kind_nxt  = KIND_SINGLE;
          cells_nxt = CELLS_W'(1);
          stage_nxt = ST_PRE;
          drive_nxt = 1'b0;
        end else if (pop_item.ge_pack2) begin
          kind_nxt  = KIND_PACK;
          cells_nxt = CELLS_W'(2);
          stage_nxt = ST_PACK;
          drive_nxt = 1'b0;
        end
      end
      ST_PACK: begin
        duty_nxt  = PRE_DUTY;
        drive_nxt = 1'b1;
        if (pop_item.ge_pack2) begin
          cells_nxt = pop_item.ge_pack7 ? CELLS_W'(7) :
                      pop_item.ge_pack4 ? CELLS_W'(4) : CELLS_W'(2);
          stage_nxt = ST_PRE;
          drive_nxt = 1'b0;
        end else begin
          kind_nxt  = KIND_UNKNOWN;
          cells_nxt = '0;
          stage_nxt = ST_ERROR;
        end
      end
      ST_PRE: begin
        drive_nxt = 1'b1;
        if (v_ext > thr_low) begin
          stage_nxt = ST_FAST;
          drive_nxt = 1'b0;
        end
        if (v_ext > thr_over) stage_nxt = ST_TYPE;
        duty_nxt = regulate(duty_r, cur_ext, pre_lo, pre_hi, cfg.max_duty);
        if (pop_item.is_zero) begin
          kind_nxt  = KIND_UNKNOWN;
          cells_nxt = '0;
          stage_nxt = ST_CELL;
        end
      end
      ST_FAST: begin
        drive_nxt = 1'b1;
        if (v_ext < thr_low) begin
          stage_nxt = ST_PRE;
          drive_nxt = 1'b0;
        end else begin
          if (v_ext > thr_full) stage_nxt = ST_TRICKLE;
          if (v_ext > thr_over) stage_nxt = ST_TYPE;
          duty_nxt = regulate(duty_r, cur_ext, fast_lo, fast_hi, cfg.max_duty);
          if (pop_item.is_zero) begin
            kind_nxt  = KIND_UNKNOWN;
            cells_nxt = '0;
            stage_nxt = ST_CELL;
          end
        end
      end
      ST_TRICKLE: begin
        duty_nxt  = PRE_DUTY;
        drive_nxt = 1'b1;
        if (v_ext > thr_over) stage_nxt = ST_TYPE;
        if (v_ext < thr_low) begin
          stage_nxt = ST_PRE;
          drive_nxt = 1'b0;
        end else begin
          // A pulled cell leaves zero cells, so the mid check cannot hit
          if (pop_item.is_zero) begin
            kind_nxt  = KIND_UNKNOWN;
            cells_nxt = '0;
            stage_nxt = ST_CELL;
          end else begin
            mid_hit = v_ext < thr_mid;
          end
          if (mid_hit) begin
            stage_nxt = ST_FAST;
          end else begin
            trick_nxt = trick_r + 1'b1;
            if (trick_nxt >= cfg.trickle_limit) begin
              stage_nxt = ST_STOP;
              drive_nxt = 1'b0;
              trick_nxt = '0;
            end
          end
        end
      end
      ST_STOP, ST_ERROR: begin
        drive_nxt = 1'b0;
        if (v_ext < thr_mid) begin
          stage_nxt = ST_PRE;
        end else if (pop_item.is_zero) begin
          kind_nxt  = KIND_UNKNOWN;
          cells_nxt = '0;
          stage_nxt = ST_CELL;
        end
      end
    endcase
  end

  // Hold state; load it and raise the result beat when a tick is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_CELL;
      kind_r      <= KIND_UNKNOWN;
      cells_r     <= '0;
      duty_r      <= PRE_DUTY;
      drive_r     <= 1'b0;
      trick_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        stage_r <= stage_nxt;
        kind_r  <= kind_nxt;
        cells_r <= cells_nxt;
        duty_r  <= duty_nxt;
        drive_r <= drive_nxt;
        trick_r <= trick_nxt;
      end
      if (pop_ready) begin
        out_valid_r <= pop_valid;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.stage_now = stage_r;
  assign out_ch.kind_now  = kind_r;
  assign out_ch.cells_now = cells_r;
  assign out_ch.duty_out  = duty_r;
  assign out_ch.drive_on  = drive_r;

endmodule

[bench/nicd_charge_monitor.sv]
// Charge controller monitor: tracks the charger state per tick and checks every result beat.
`timescale 1ns / 1ps

module nicd_charge_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  nicd_in_if                             in_mon,
  nicd_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [nicd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [nicd_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                    fail_count,
  output int unsigned                    pending
);
  import nicd_pkg::*;

  typedef enum logic [STAGE_W-1:0] {
    STAGE_CELL, STAGE_TYPE, STAGE_PACK, STAGE_PRE,
    STAGE_FAST, STAGE_TRICKLE, STAGE_STOP, STAGE_ERROR
  } stage_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_SINGLE  = 2'd1,
    KIND_PACK    = 2'd3
  } kind_e;

  typedef struct packed {
    stage_e             stage;
    kind_e              kind;
    logic [CELLS_W-1:0] cells;
    logic [DUTY_W-1:0]  duty;
    logic               drive;
  } charger_view_t;

  // Register copy and charger state as the block should hold them
  cfg_t               regs;
  stage_e             stage_q;
  kind_e              kind_q;
  logic [CELLS_W-1:0] cells_q;
  logic [DUTY_W-1:0]  duty_q;
  logic               drive_q;
  logic [CNT_W-1:0]   trickle_q;

  charger_view_t expected_views[$];
  int unsigned   fails;

  // Step the duty toward the current window: raise first, then lower
  task automatic trim_duty(input int unsigned cur, input int unsigned lo,
                           input int unsigned hi);
    int unsigned raised;
    if (cur < lo) begin
      raised = duty_q + 1;
      if (raised > regs.max_duty) raised = regs.max_duty;
      duty_q = raised[DUTY_W-1:0];
    end
    if (cur > hi) begin
      duty_q = (duty_q <= 1) ? 5'd1 : duty_q - 5'd1;
    end
  endtask

  // Battery removed: forget the cell and go back to detection
  task automatic pull_cell();
    kind_q  = KIND_UNKNOWN;
    cells_q = '0;
    stage_q = STAGE_CELL;
  endtask

  // Advance the charger by one tick and queue the view it produces
  task automatic predict_tick(input int unsigned v, input int unsigned cur);
    int unsigned   n;
    charger_view_t view;
    n = cells_q;
    case (stage_q)
      STAGE_CELL: begin
        if (v < regs.empty_level_cv) begin
          duty_q  = PRE_DUTY;
          drive_q = 1'b1;
        end else begin
          stage_q = STAGE_TYPE;
          drive_q = 1'b0;
        end
      end
      STAGE_TYPE: begin
        duty_q  = PRE_DUTY;
        drive_q = 1'b1;
        if (v < SINGLE_MAX_CV) begin
          kind_q  = KIND_SINGLE;
          cells_q = 3'd1;
          stage_q = STAGE_PRE;
          drive_q = 1'b0;
        end else if (v >= PACK2_CV) begin
          kind_q  = KIND_PACK;
          cells_q = 3'd2;
          stage_q = STAGE_PACK;
          drive_q = 1'b0;
        end
      end
      STAGE_PACK: begin
        duty_q  = PRE_DUTY;
        drive_q = 1'b1;
        if (v >= PACK2_CV) begin
          cells_q = (v >= PACK7_CV) ? 3'd7 : (v >= PACK4_CV) ? 3'd4 : 3'd2;
          stage_q = STAGE_PRE;
          drive_q = 1'b0;
        end else begin
          // pack too low: error stop, drive left on for this tick
          kind_q  = KIND_UNKNOWN;
          cells_q = '0;
          stage_q = STAGE_ERROR;
        end
      end
      STAGE_PRE: begin
        drive_q = 1'b1;
        if (v > CELL_LOW_CV * n) begin
          stage_q = STAGE_FAST;
          drive_q = 1'b0;
        end
        if (v > CELL_OVER_CV * n) stage_q = STAGE_TYPE;
        if (n == 7) trim_duty(cur, S7_PRE_LO, S7_PRE_HI);
        else trim_duty(cur, regs.pre_target_ma,
                       int'(regs.pre_target_ma) + int'(regs.pre_window_ma));
        if (v == 0) pull_cell();
      end
      STAGE_FAST: begin
        drive_q = 1'b1;
        if (v < CELL_LOW_CV * n) begin
          stage_q = STAGE_PRE;
          drive_q = 1'b0;
        end else begin
          if (v > CELL_FULL_CV * n) stage_q = STAGE_TRICKLE;
          if (v > CELL_OVER_CV * n) stage_q = STAGE_TYPE;
          if (n == 7) trim_duty(cur, S7_FAST_LO, S7_FAST_HI);
          else trim_duty(cur, regs.fast_target_ma,
                         int'(regs.fast_target_ma) + int'(regs.fast_window_ma));
          if (v == 0) pull_cell();
        end
      end
      STAGE_TRICKLE: begin
        duty_q  = 5'd1;
        drive_q = 1'b1;
        if (v > CELL_OVER_CV * n) stage_q = STAGE_TYPE;
        if (v < CELL_LOW_CV * n) begin
          stage_q = STAGE_PRE;
          drive_q = 1'b0;
        end else begin
          if (v == 0) pull_cell();
          // mid threshold uses the cell count after a possible removal
          if (v < CELL_MID_CV * cells_q) begin
            stage_q = STAGE_FAST;
          end else begin
            trickle_q = trickle_q + 1'b1;
            if (trickle_q >= regs.trickle_limit) begin
              stage_q   = STAGE_STOP;
              drive_q   = 1'b0;
              trickle_q = '0;
            end
          end
        end
      end
      default: begin
        // stop and error stop behave alike
        drive_q = 1'b0;
        if (v < CELL_MID_CV * n) stage_q = STAGE_PRE;
        else if (v == 0) pull_cell();
      end
    endcase
    view.stage = stage_q;
    view.kind  = kind_q;
    view.cells = cells_q;
    view.duty  = duty_q;
    view.drive = drive_q;
    expected_views.push_back(view);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // Snoop writes, predict on input beats, compare on result beats
  always @(posedge clk) begin
    charger_view_t want;
    if (!rst_n) begin
      regs.empty_level_cv = 10'd50;
      regs.pre_target_ma  = 11'd350;
      regs.pre_window_ma  = 10'd100;
      regs.fast_target_ma = 11'd700;
      regs.fast_window_ma = 10'd100;
      regs.max_duty       = 5'd3;
      regs.trickle_limit  = 10'd186;
      stage_q   = STAGE_CELL;
      kind_q    = KIND_UNKNOWN;
      cells_q   = '0;
      duty_q    = 5'd1;
      drive_q   = 1'b0;
      trickle_q = '0;
      expected_views.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_EMPTY_LEVEL: regs.empty_level_cv = cfg_data[VOLT_W-1:0];
          CFG_PRE_TARGET:  regs.pre_target_ma  = cfg_data[CUR_W-1:0];
          CFG_PRE_WINDOW:  regs.pre_window_ma  = cfg_data[9:0];
          CFG_FAST_TARGET: regs.fast_target_ma = cfg_data[CUR_W-1:0];
          CFG_FAST_WINDOW: regs.fast_window_ma = cfg_data[9:0];
          CFG_MAX_DUTY:    regs.max_duty       = cfg_data[DUTY_W-1:0];
          CFG_TRICKLE_LIM: regs.trickle_limit  = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_tick(in_mon.voltage_cv, in_mon.current_ma);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result beat with nothing expected, got stage %0d duty %0d",
                   $time, out_mon.stage_now, out_mon.duty_out);
          fails++;
        end else begin
          want = expected_views.pop_front();
          check_field("stage_now", want.stage, out_mon.stage_now);
          check_field("kind_now", want.kind, out_mon.kind_now);
          check_field("cells_now", want.cells, out_mon.cells_now);
          check_field("duty_out", want.duty, out_mon.duty_out);
          check_field("drive_on", want.drive, out_mon.drive_on);
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_views.size();
  end

endmodule

[bench/nicd_charge_controller_test.sv]
// Testbench top for the charge controller: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module nicd_charge_controller_test;
  import nicd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_TICKS   = 180;
  localparam int unsigned PHASE_COUNT   = 7;
  localparam int unsigned DIRECTED_LEN  = 24;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          fail_count;
  int unsigned          pending;

  int unsigned cycles = 0;
  int unsigned ticks_sent;
  int unsigned phase_ticks;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Register values last written, used to aim voltages and currents
  int unsigned lvl_empty   = 50;
  int unsigned lvl_pre_lo  = 350;
  int unsigned lvl_pre_w   = 100;
  int unsigned lvl_fast_lo = 700;
  int unsigned lvl_fast_w  = 100;
  int unsigned lvl_trickle = 186;

  // Corners: stay empty, seven-cell regulation, pull-out, trickle, pack too low
  int unsigned dir_v[DIRECTED_LEN] = '{0, 1023, 1023, 1023, 900, 920, 920, 920,
                                       920, 900, 0, 0, 100, 120, 131, 150,
                                       145, 140, 151, 170, 250, 199, 5, 0};
  int unsigned dir_c[DIRECTED_LEN] = '{0, 2047, 500, 0, 0, 2047, 0, 0,
                                       0, 200, 1000, 0, 0, 0, 300, 750,
                                       100, 900, 2047, 0, 0, 0, 0, 0};

  nicd_in_if  in_ch();
  nicd_out_if out_ch();

  nicd_charge_controller DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  nicd_charge_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stall the result channel at random; hold it low during reset
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one tick, idling first at random, and hold it until taken
  task automatic send_tick(input int unsigned v, input int unsigned c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.voltage_cv <= v[VOLT_W-1:0];
    in_ch.current_ma <= c[CUR_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    phase_ticks++;
  endtask

  // Wait until every result is back, then let the pipeline go quiet
  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_settings(input int unsigned e, input int unsigned pt,
                               input int unsigned pw, input int unsigned ft,
                               input int unsigned fw, input int unsigned md,
                               input int unsigned tl);
    write_reg(CFG_EMPTY_LEVEL, e);
    write_reg(CFG_PRE_TARGET, pt);
    write_reg(CFG_PRE_WINDOW, pw);
    write_reg(CFG_FAST_TARGET, ft);
    write_reg(CFG_FAST_WINDOW, fw);
    write_reg(CFG_MAX_DUTY, md);
    write_reg(CFG_TRICKLE_LIM, tl);
    cfg_we      <= 1'b0;
    lvl_empty   = e;
    lvl_pre_lo  = pt;
    lvl_pre_w   = pw;
    lvl_fast_lo = ft;
    lvl_fast_w  = fw;
    lvl_trickle = tl;
  endtask

  // Current sample: mostly near a regulation limit, sometimes anywhere
  function automatic int unsigned pick_current();
    int unsigned base;
    int          x;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 2047);
      1: return $urandom_range(0, 1) ? 2047 : 0;
      default: begin
        case ($urandom_range(0, 7))
          0: base = lvl_pre_lo;
          1: base = lvl_pre_lo + lvl_pre_w;
          2: base = lvl_fast_lo;
          3: base = lvl_fast_lo + lvl_fast_w;
          4: base = 50;
          5: base = 370;
          6: base = 120;
          default: base = 400;
        endcase
        x = int'(base) + int'($urandom_range(0, 8)) - 4;
        if (x < 0) x = 0;
        if (x > 2047) x = 2047;
        return x;
      end
    endcase
  endfunction

  // Pack voltage for a per-cell level, spread over the rounding of n cells
  function automatic int unsigned cell_volts(input int pc, input int unsigned n);
    int x;
    x = pc * int'(n) - int'($urandom_range(0, n - 1));
    if (x < 0) x = 0;
    if (x > 1023) x = 1023;
    return x;
  endfunction

  // One battery from insertion through pre, fast and trickle charge, to stop if the trickle limit is reached
  task automatic charge_episode();
    int unsigned n;
    int unsigned v;
    int unsigned hold;
    int          pc;
    int unsigned steps;
    case ($urandom_range(0, 3))
      0: n = 1;
      1: n = 2;
      2: n = 4;
      default: n = 7;
    endcase
    // pull the cell so detection starts over
    repeat ($urandom_range(1, 4)) send_tick(0, pick_current());
    v = lvl_empty + $urandom_range(0, 20);
    send_tick((v > 1023) ? 1023 : v, pick_current());
    if (n == 1) begin
      send_tick($urandom_range(1, 149), pick_current());
    end else begin
      send_tick($urandom_range(200, 1023), pick_current());
      case (n)
        2: v = $urandom_range(200, 399);
        4: v = $urandom_range(400, 699);
        default: v = $urandom_range(700, 1023);
      endcase
      // now and then a pack that sags below the two-cell level
      if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 199);
      send_tick(v, pick_current());
    end
    // ramp up through pre and fast charge
    pc = $urandom_range(118, 130);
    steps = 0;
    while (pc < 150 && steps < 60) begin
      send_tick(cell_volts(pc, n), pick_current());
      pc = pc + int'($urandom_range(0, 4)) - 1;
      steps++;
    end
    send_tick(cell_volts(150, n), pick_current());
    // trickle band, with the odd excursion either side
    hold = $urandom_range(1, (lvl_trickle + 3 > 40) ? 40 : lvl_trickle + 3);
    repeat (hold) begin
      case ($urandom_range(0, 19))
        0: pc = 141;
        1: pc = 151;
        default: pc = $urandom_range(142, 150);
      endcase
      send_tick(cell_volts(pc, n), pick_current());
    end
    repeat ($urandom_range(0, 3)) send_tick(cell_volts($urandom_range(140, 150), n),
                                            pick_current());
  endtask

  initial begin
    int unsigned phase;
    int unsigned k;
    int unsigned pause_at;
    bit          paused;
    in_ch.valid      = 1'b0;
    in_ch.voltage_cv = '0;
    in_ch.current_ma = '0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_EMPTY_LEVEL;
    cfg_data         = '0;
    rst_n            = 1'b0;
    ticks_sent       = 0;
    send_idle_pct    = 12;
    recv_idle_pct    = 77;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      // receiver sparse first, then sender sparse, then full rate
      if (phase < 3) begin
        send_idle_pct = 12;
        recv_idle_pct = 77;
      end else if (phase < 5) begin
        send_idle_pct = 77;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_ticks = 0;
      if (phase == 0) begin
        for (k = 0; k < DIRECTED_LEN; k++) send_tick(dir_v[k], dir_c[k]);
      end else begin
        case (phase)
          1: load_settings(50, 350, 100, 700, 100, 3, 12);
          2: load_settings(0, 0, 0, 0, 0, 1, 1);
          3: load_settings(1023, 2047, 1023, 2047, 1023, 19, 1023);
          4: load_settings($urandom_range(20, 140), $urandom_range(100, 900),
                           $urandom_range(0, 300), $urandom_range(300, 1500),
                           $urandom_range(0, 400), $urandom_range(1, 19),
                           $urandom_range(2, 30));
          5: load_settings($urandom_range(0, 1023), $urandom_range(0, 2047),
                           $urandom_range(0, 1023), $urandom_range(0, 2047),
                           $urandom_range(0, 1023), 0, 0);
          default: load_settings($urandom_range(20, 140), $urandom_range(100, 900),
                                 $urandom_range(0, 300), $urandom_range(300, 1500),
                                 $urandom_range(0, 400), 31, $urandom_range(5, 25));
        endcase
        pause_at = $urandom_range(20, PHASE_TICKS - 20);
        paused   = 1'b0;
        while (phase_ticks < PHASE_TICKS) begin
          // hold off new ticks until the block has answered every one
          if (!paused && phase_ticks >= pause_at) begin
            in_ch.valid <= 1'b0;
            drain_results();
            paused = 1'b1;
          end
          if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3))
              send_tick($urandom_range(0, 1023), $urandom_range(0, 2047));
          end else begin
            charge_episode();
          end
        end
      end
      in_ch.valid <= 1'b0;
      drain_results();
    end

    $display("Checked %0d ticks across %0d register settings", ticks_sent, PHASE_COUNT);
    $display("covering detection, pack sizing, pre/fast/trickle charge, stop and error");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
